>>> sv/stif_pkg.sv
// stif_pkg: shared constants and types for the sorted table insert/find block.
// Used by stif_cell and sorted_table_insert_find. No dependencies.
`default_nettype none

package stif_pkg;

	// table geometry
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// per-cell flags handed to the top level
	typedef struct packed {
		logic place;  // this slot is at or past the insert point
		logic first;  // this slot is the insert point
		logic hit;    // insert point holds a value equal to the key
	} stif_cell_st_t;

endpackage

`default_nettype wire

>>> sv/stif_cell.sv
// stif_cell: one slot of the sorted table; compares its entry with the key
// and takes its lower neighbor's entry or the key on an insert. Uses stif_pkg.
`default_nettype none

module stif_cell
	import stif_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic                    occ,
	input  wire logic signed [VAL_W-1:0] key,
	input  wire logic                    prev_place,
	input  wire logic signed [VAL_W-1:0] prev_entry,
	output logic signed [VAL_W-1:0]      entry,
	output stif_cell_st_t                st
);

	logic signed [VAL_W-1:0] entry_q;

	// compare flags; an empty slot always counts as an insert point candidate
	always_comb begin
		st.place = !occ || (entry_q >= key);
		st.first = st.place && !prev_place;
		st.hit   = st.first && occ && (entry_q == key);
	end

	assign entry = entry_q;

	// shift up past the insert point, drop the key at it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (prev_place) begin
				entry_q <= prev_entry;
			end else if (st.place) begin
				entry_q <= key;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/sorted_table_insert_find.sv
// sorted_table_insert_find: ascending table of signed 32-bit keys built as a row of cells.
// Uses stif_pkg and stif_cell.
//
// Usage:
//   Input channel (in_valid / in_stall, operation, value): a transaction is taken at a
//   rising edge with in_valid high and in_stall low. operation selects insert or find.
//   Output channel (out_valid / out_stall, index, status, count): one result per input
//   transaction, in order, held stable while out_stall is high.
//   The result appears in the output register the cycle after the input transaction.
//   Throughput is one transaction per cycle while in_stall is low; every cell compares
//   its entry with the key in parallel and shifts from its neighbor in the same cycle.
//   An insert returns the slot it used, a find the first equal slot (status not found
//   and index 0 on a miss), an insert into a full table returns status full, index 0.
//   count is the number of stored entries after the operation.
//   When the receiver stalls with a result waiting, in_stall goes high and no new input
//   is taken until that result is accepted.
//   Reset (arst_n low) empties the table and drops any pending result; no clearing
//   pass is needed, the block accepts input as soon as reset is released.
`default_nettype none

module sorted_table_insert_find
	import stif_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    operation,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [IDX_W-1:0]             index,
	output logic [1:0]                   status,
	output logic [IDX_W-1:0]             count
);

	logic                    out_valid_q;
	logic [IDX_W-1:0]        fill_q;
	logic [IDX_W-1:0]        index_q;
	logic [1:0]              status_q;
	logic [IDX_W-1:0]        count_q;

	logic                    accept;
	logic                    full;
	logic                    wr_en;
	logic [DEPTH-1:0]        occ;
	logic [DEPTH-1:0]        place;
	logic [DEPTH-1:0]        first;
	logic [DEPTH-1:0]        hit;
	logic signed [VAL_W-1:0] entry [DEPTH];
	stif_cell_st_t           cell_st [DEPTH];
	logic [IDX_W-1:0]        pos;
	logic                    found;
	logic [IDX_W-1:0]        res_index;
	logic [1:0]              res_status;
	logic [IDX_W-1:0]        res_count;

	// handshake
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign full      = (fill_q == IDX_W'(DEPTH));
	assign wr_en     = accept && (operation == OP_INSERT) && !full;
	assign out_valid = out_valid_q;
	assign index     = index_q;
	assign status    = status_q;
	assign count     = count_q;

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    prev_place;
		logic signed [VAL_W-1:0] prev_entry;

		if (i == 0) begin : g_head
			assign prev_place = 1'b0;
			assign prev_entry = value;
		end else begin : g_link
			assign prev_place = place[i-1];
			assign prev_entry = entry[i-1];
		end

		assign occ[i]   = (IDX_W'(i) < fill_q);
		assign place[i] = cell_st[i].place;
		assign first[i] = cell_st[i].first;
		assign hit[i]   = cell_st[i].hit;

		stif_cell u_cell (
			.clk        (clk),
			.wr_en      (wr_en),
			.occ        (occ[i]),
			.key        (value),
			.prev_place (prev_place),
			.prev_entry (prev_entry),
			.entry      (entry[i]),
			.st         (cell_st[i])
		);
	end

	// one-hot insert point to binary index
	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos = pos | (first[i] ? IDX_W'(i) : '0);
		end
		found = |hit;
	end

	// result of this transaction
	always_comb begin
		res_index  = '0;
		res_status = ST_OK;
		res_count  = fill_q;
		case (operation)
			OP_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					res_index = pos;
					res_count = fill_q + IDX_W'(1);
				end
			end
			OP_FIND: begin
				if (found) begin
					res_index = pos;
				end else begin
					res_status = ST_MISS;
				end
			end
			default: begin
				res_status = ST_MISS;
			end
		endcase
	end

	// fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				fill_q <= fill_q + IDX_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			index_q  <= res_index;
			status_q <= res_status;
			count_q  <= res_count;
		end
	end

endmodule

`default_nettype wire
